// File: rtl/core/akd_pkg.sv
package akd_pkg;

  // Default build parameters.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int MAX_KEYS_DEF    = 4;

  // Fixed field and register widths.
  localparam int RAW_W     = 16;
  localparam int STAMP_W   = 32;
  localparam int KEY_W     = 3;
  localparam int REPEAT_W  = 16;
  localparam int SUM_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int NUM_THR   = 4;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUTTON_COUNT = 3'd0,
    REG_THRESHOLD_1  = 3'd1,
    REG_THRESHOLD_2  = 3'd2,
    REG_THRESHOLD_3  = 3'd3,
    REG_THRESHOLD_4  = 3'd4,
    REG_DEBOUNCE     = 3'd5
  } cfg_reg_e;

  // Request actions and result kinds.
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_POLL    = 1'b1;
  localparam logic KIND_CLICK  = 1'b0;
  localparam logic KIND_POLL   = 1'b1;

  // Register values after reset.
  localparam logic [KEY_W-1:0]     BUTTON_COUNT_RST = 3'd4;
  localparam logic [CFG_DAT_W-1:0] THRESHOLD_1_RST  = 16'd800;
  localparam logic [CFG_DAT_W-1:0] THRESHOLD_2_RST  = 16'd600;
  localparam logic [CFG_DAT_W-1:0] THRESHOLD_3_RST  = 16'd400;
  localparam logic [CFG_DAT_W-1:0] THRESHOLD_4_RST  = 16'd300;
  localparam logic [CFG_DAT_W-1:0] DEBOUNCE_RST     = 16'd50;

  typedef struct packed {
    logic [KEY_W-1:0]                   button_count;
    logic [NUM_THR-1:0][CFG_DAT_W-1:0]  threshold;
    logic [CFG_DAT_W-1:0]               debounce_time;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [RAW_W-1:0]   raw_sample;
    logic [STAMP_W-1:0] sample_time;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic [KEY_W-1:0]    button;
    logic [REPEAT_W-1:0] repeat_count;
  } out_item_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TIME  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_CLASS = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

endpackage

// File: rtl/core/analog_ladder_key_decoder.sv
// One request is worked on at a time: the input stalls while the sequencer is not idle.
// A release sample is handled in idle. A poll answer goes straight to the emit state; a
// sample that extends a press goes to the time check and, once the debounce time is past,
// via the 32-step bit-serial sum/count divider and the classify state to the emit state.
// The output register holds one result while the next request is worked on.
// Reset (rst_ni low, asynchronous) restores register defaults and clears control state.
module analog_ladder_key_decoder #(
  parameter int SAMPLE_BITS = akd_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = akd_pkg::COUNT_BITS_DEF,
  parameter int TIME_BITS   = akd_pkg::TIME_BITS_DEF,
  parameter int MAX_KEYS    = akd_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [akd_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [akd_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  akd_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output akd_pkg::out_item_t            out_data_o
);
  import akd_pkg::*;

  localparam logic [KEY_W-1:0]    KEYS_MAX = KEY_W'(MAX_KEYS);
  localparam logic [REPEAT_W-1:0] REP_MAX  = '1;

  cfg_t        cfg;
  div_status_t div_stat;
  logic [SUM_W-1:0] avg;

  state_e                state_q, state_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [TIME_BITS-1:0]  start_q, start_d;
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic [KEY_W-1:0]      last_q, last_d;
  logic [REPEAT_W-1:0]   rep_q, rep_d;
  out_item_t             pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic                   accept;
  logic                   div_start;
  logic                   out_free;
  logic [KEY_W-1:0]       keys;
  logic [1:0]             gate_idx;
  logic [CFG_DAT_W-1:0]   gate;
  logic [SAMPLE_BITS-1:0] raw_eff;
  logic [RAW_W-1:0]       raw_ext;
  logic [SUM_W:0]         sum_add;
  logic [TIME_BITS-1:0]   elapsed;
  logic [KEY_W-1:0]       key;

  akd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  akd_serial_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .quotient_o (avg),
    .status_o   (div_stat)
  );

  // Keys in use, clamped to 1..MAX_KEYS; the last threshold in use gates a press.
  always_comb begin
    if (cfg.button_count == '0) begin
      keys = KEY_W'(1);
    end else if (cfg.button_count > KEYS_MAX) begin
      keys = KEYS_MAX;
    end else begin
      keys = cfg.button_count;
    end
    gate_idx = 2'(keys - 1'b1);
    gate     = cfg.threshold[gate_idx];
  end

  assign raw_eff  = in_data_i.raw_sample[SAMPLE_BITS-1:0];
  assign raw_ext  = RAW_W'(raw_eff);
  assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(raw_eff);
  assign elapsed  = now_q - start_q;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Classify the average: the first threshold in list order that it reaches wins.
  always_comb begin
    key = '0;
    for (int i = NUM_THR - 1; i >= 0; i--) begin
      if ((KEY_W'(i) < keys) && (avg >= SUM_W'(cfg.threshold[i]))) begin
        key = KEY_W'(keys - KEY_W'(i));
      end
    end
    if (avg <= SUM_W'(gate)) begin
      key = '0;
    end
  end

  // Request sequencer.
  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    start_d   = start_q;
    now_d     = now_q;
    last_d    = last_q;
    rep_d     = rep_q;
    pend_d    = pend_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.action == ACT_POLL) begin
            pend_d.result_kind  = KIND_POLL;
            pend_d.button       = last_q;
            pend_d.repeat_count = '0;
            last_d              = '0;
            state_d             = ST_EMIT;
          end else if (raw_ext <= gate) begin
            sum_d = '0;
            cnt_d = '0;
            rep_d = '0;
          end else begin
            now_d = TIME_BITS'(in_data_i.sample_time);
            if (cnt_q == '0) begin
              start_d = TIME_BITS'(in_data_i.sample_time);
            end
            if (cnt_q != '1) begin
              sum_d = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
              cnt_d = cnt_q + 1'b1;
            end
            state_d = ST_TIME;
          end
        end
      end
      ST_TIME: begin
        if (elapsed > TIME_BITS'(cfg.debounce_time)) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: begin
        pend_d.result_kind = KIND_CLICK;
        pend_d.button      = key;
        if (key == last_q) begin
          rep_d = (rep_q != REP_MAX) ? rep_q + 1'b1 : rep_q;
          pend_d.repeat_count = (rep_q != REP_MAX) ? rep_q + 1'b1 : rep_q;
        end else begin
          last_d              = key;
          rep_d               = REPEAT_W'(1);
          pend_d.repeat_count = REPEAT_W'(1);
        end
        sum_d   = '0;
        cnt_d   = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: loaded from the pending result when free.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_valid_d = 1'b1;
      out_d       = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      start_q     <= '0;
      last_q      <= '0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      start_q     <= start_d;
      last_q      <= last_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The divider only runs while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == ST_DIV))
    else $error("divider busy outside the divide state");

  // Every sample added to the sum is non-zero, so sum and count clear together.
  a_sum_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) == (sum_q == '0))
    else $error("sample sum and sample count disagree");

  // A pending result is handed to the output register once it is free.
  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && out_free) |=> (out_valid_o && (state_q == ST_IDLE)))
    else $error("pending result not loaded");

  // A click never names a key beyond those in use.
  a_click_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLASS) |-> (key <= keys))
    else $error("decoded key out of range");

endmodule

// File: rtl/core/akd_cfg_regs.sv
module akd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [akd_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [akd_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  output akd_pkg::cfg_t                 cfg_o
);
  import akd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BUTTON_COUNT: cfg_d.button_count  = cfg_wdata_i[KEY_W-1:0];
        REG_THRESHOLD_1:  cfg_d.threshold[0]  = cfg_wdata_i;
        REG_THRESHOLD_2:  cfg_d.threshold[1]  = cfg_wdata_i;
        REG_THRESHOLD_3:  cfg_d.threshold[2]  = cfg_wdata_i;
        REG_THRESHOLD_4:  cfg_d.threshold[3]  = cfg_wdata_i;
        REG_DEBOUNCE:     cfg_d.debounce_time = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.button_count  <= BUTTON_COUNT_RST;
      cfg_q.threshold[0]  <= THRESHOLD_1_RST;
      cfg_q.threshold[1]  <= THRESHOLD_2_RST;
      cfg_q.threshold[2]  <= THRESHOLD_3_RST;
      cfg_q.threshold[3]  <= THRESHOLD_4_RST;
      cfg_q.debounce_time <= DEBOUNCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/akd_serial_div.sv
module akd_serial_div #(
  parameter int DIVIDEND_W = akd_pkg::SUM_W,
  parameter int DIVISOR_W  = akd_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output akd_pkg::div_status_t  status_o
);
  import akd_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  den_q, den_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]      step_q, step_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One quotient bit per cycle: the dividend shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  always_comb begin
    trial  = {rem_q, quo_q[DIVIDEND_W-1]};
    fits   = trial >= {1'b0, den_q};
    diff   = trial - {1'b0, den_q};
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d  = {quo_q[DIVIDEND_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// File: test/analog_ladder_key_decoder_tb.sv
module analog_ladder_key_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import akd_pkg::*;

  localparam int unsigned RAND_PHASES    = 12;
  localparam int unsigned PHASE_REQS     = 160;
  localparam int unsigned HOLD_PHASE     = 5;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 60;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS    = 20;
  localparam int unsigned RAW_TOP        = 2**RAW_W - 1;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                 clk_i     = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  out_item_t            out_data;

  // Requests waiting to be offered, and key results still to arrive.
  in_item_t  pending_q [$];
  out_item_t result_q  [$];

  // Register copies and decoder state of the prediction.
  logic [KEY_W-1:0]     btn_cfg;
  logic [CFG_DAT_W-1:0] thr_cfg [NUM_THR];
  logic [CFG_DAT_W-1:0] dbn_cfg;
  logic [SUM_W-1:0]     press_sum;
  logic [15:0]          press_cnt;
  logic [STAMP_W-1:0]   press_start;
  logic [KEY_W-1:0]     last_key;
  logic [REPEAT_W-1:0]  repeat_cnt;

  logic [STAMP_W-1:0] stamp_now;
  bit                 idle_on;
  bit                 req_taken;
  bit                 hold_req;
  bit                 hold_done;
  int unsigned        send_gap;
  int unsigned        stall_left;
  int unsigned        hold_left;
  int unsigned        queued_cnt;
  int unsigned        req_cnt;
  int unsigned        click_cnt;
  int unsigned        poll_cnt;
  int unsigned        err_cnt;
  int unsigned        report_cnt;
  int unsigned        setting_cnt;
  int unsigned        idle_cycles;

  analog_ladder_key_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Key count in use: zero counts as one, anything above the maximum as the maximum.
  function automatic int unsigned keys_used();
    if (btn_cfg == '0) return 1;
    if (btn_cfg > MAX_KEYS_DEF) return MAX_KEYS_DEF;
    return btn_cfg;
  endfunction

  // Works out what one accepted request does to the decoder and what it returns.
  function automatic bit decode_request(input in_item_t req, output out_item_t res);
    int unsigned        keys;
    int                 i;
    logic [CFG_DAT_W-1:0] gate;
    logic [SUM_W:0]     wide_sum;
    logic [SUM_W-1:0]   avg;
    logic [STAMP_W-1:0] elapsed;
    logic [KEY_W-1:0]   key;
    res  = '0;
    keys = keys_used();
    gate = thr_cfg[keys - 1];

    // A poll hands back the last clicked key and forgets it.
    if (req.action == ACT_POLL) begin
      res.result_kind  = KIND_POLL;
      res.button       = last_key;
      res.repeat_count = '0;
      last_key         = '0;
      return 1'b1;
    end

    // At or below the gate the press is over.
    if (req.raw_sample <= gate) begin
      press_sum  = '0;
      press_cnt  = '0;
      repeat_cnt = '0;
      return 1'b0;
    end

    // Accumulate, holding the count once it is full and the sum at its ceiling.
    if (press_cnt == '0) press_start = req.sample_time;
    if (press_cnt != '1) begin
      wide_sum  = press_sum + req.raw_sample;
      press_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
      press_cnt = press_cnt + 1'b1;
    end

    elapsed = req.sample_time - press_start;
    if (elapsed <= dbn_cfg) return 1'b0;

    // Classify the average; the first threshold in order that it reaches wins.
    avg = (press_cnt != '0) ? press_sum / press_cnt : '0;
    key = '0;
    if (avg > gate) begin
      for (i = int'(keys) - 1; i >= 0; i--) begin
        if (avg >= thr_cfg[i]) key = KEY_W'(int'(keys) - i);
      end
    end

    if (key == last_key) begin
      if (repeat_cnt != '1) repeat_cnt = repeat_cnt + 1'b1;
    end else begin
      last_key   = key;
      repeat_cnt = REPEAT_W'(1);
    end
    press_sum = '0;
    press_cnt = '0;

    res.result_kind  = KIND_CLICK;
    res.button       = key;
    res.repeat_count = repeat_cnt;
    return 1'b1;
  endfunction

  task automatic send_sample(input logic [RAW_W-1:0] raw, input logic [STAMP_W-1:0] stamp);
    in_item_t req;
    req.action      = ACT_SAMPLE;
    req.raw_sample  = raw;
    req.sample_time = stamp;
    pending_q.push_back(req);
    queued_cnt++;
  endtask

  task automatic send_poll();
    in_item_t req;
    req.action      = ACT_POLL;
    req.raw_sample  = RAW_W'($urandom);
    req.sample_time = $urandom;
    pending_q.push_back(req);
    queued_cnt++;
  endtask

  // A press near one key's level that lasts just past the debounce time.
  task automatic queue_press(input int unsigned key_idx);
    int unsigned acc;
    int unsigned step;
    int unsigned lvl;
    int unsigned gate;
    gate = thr_cfg[keys_used() - 1];
    acc  = 0;
    step = 0;
    do begin
      acc       += step;
      stamp_now += step;
      lvl = thr_cfg[key_idx] + $urandom_range(0, 40);
      if (lvl > RAW_TOP) lvl = RAW_TOP;
      if (lvl <= gate && gate != RAW_TOP) lvl = gate + 1;
      send_sample(RAW_W'(lvl), stamp_now);
      step = $urandom_range(0, dbn_cfg / 3 + 2);
    end while (acc <= dbn_cfg);
  endtask

  task automatic queue_release();
    send_sample(RAW_W'($urandom_range(0, thr_cfg[keys_used() - 1])), stamp_now);
  endtask

  // Register write while the block is idle; the prediction follows at once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      REG_BUTTON_COUNT: btn_cfg    = val[KEY_W-1:0];
      REG_THRESHOLD_1:  thr_cfg[0] = val;
      REG_THRESHOLD_2:  thr_cfg[1] = val;
      REG_THRESHOLD_3:  thr_cfg[2] = val;
      REG_THRESHOLD_4:  thr_cfg[3] = val;
      REG_DEBOUNCE:     dbn_cfg    = val;
      default: ;
    endcase
  endtask

  // Wait until every request is in and every result is out, then let the block settle.
  task automatic drain();
    do begin
      @(posedge clk_i);
    end while (pending_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Request driver: offers queued requests, holding each until it is taken.
  always @(negedge clk_i) begin : tx_ctrl
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (in_valid && req_taken) nxt_valid = 1'b0;
    if (!nxt_valid && rst_n) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_q.size() != 0) begin
        nxt_data  = pending_q.pop_front();
        nxt_valid = 1'b1;
        send_gap  = pick_gap();
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Result receiver: random stalls, plus one long hold-off once a result is waiting.
  always @(negedge clk_i) begin : rx_ctrl
    if (hold_left != 0) begin
      hold_left--;
    end else if (hold_req && !hold_done && out_valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end else if (stall_left != 0) begin
      stall_left--;
    end else begin
      stall_left = pick_gap();
    end
    out_stall <= (hold_left != 0) || (stall_left != 0);
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk_i) begin : mon
    out_item_t want;
    bit        has_res;
    bit        res_taken;
    req_taken = rst_n && in_valid && !in_stall;
    res_taken = rst_n && out_valid && !out_stall;

    if (req_taken) begin
      req_cnt++;
      has_res = decode_request(in_data, want);
      if (has_res) result_q.push_back(want);
    end

    if (res_taken) begin
      if (out_data.result_kind == KIND_POLL) poll_cnt++;
      else click_cnt++;
      if (result_q.size() == 0) begin
        err_cnt++;
        if (report_cnt < MAX_REPORTS) begin
          report_cnt++;
          $display("%0t: unexpected result: expected none, got kind %0d key %0d repeat %0d",
                   $time, out_data.result_kind, out_data.button, out_data.repeat_count);
        end
      end else begin
        want = result_q.pop_front();
        if (out_data.result_kind !== want.result_kind || out_data.button !== want.button ||
            out_data.repeat_count !== want.repeat_count) begin
          err_cnt++;
          if (report_cnt < MAX_REPORTS) begin
            report_cnt++;
            $display({"%0t: mismatch: expected kind %0d key %0d repeat %0d, ",
                      "got kind %0d key %0d repeat %0d"},
                     $time, want.result_kind, want.button, want.repeat_count,
                     out_data.result_kind, out_data.button, out_data.repeat_count);
          end
        end
      end
    end

    // Watchdog on cycles in which nothing moves.
    if (!rst_n || req_taken || res_taken || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned          phase;
    int unsigned          i;
    int unsigned          key_idx;
    int unsigned          prev_idx;
    int unsigned          target;
    int unsigned          sel;
    logic [KEY_W-1:0]     new_btn;
    logic [CFG_DAT_W-1:0] new_thr [NUM_THR];
    logic [CFG_DAT_W-1:0] new_dbn;

    btn_cfg     = BUTTON_COUNT_RST;
    thr_cfg[0]  = THRESHOLD_1_RST;
    thr_cfg[1]  = THRESHOLD_2_RST;
    thr_cfg[2]  = THRESHOLD_3_RST;
    thr_cfg[3]  = THRESHOLD_4_RST;
    dbn_cfg     = DEBOUNCE_RST;
    press_sum   = '0;
    press_cnt   = '0;
    press_start = '0;
    last_key    = '0;
    repeat_cnt  = '0;
    idle_on     = 1'b1;
    setting_cnt = 1;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Directed requests under the reset settings.
    send_poll();                        // nothing clicked yet
    send_sample(16'd0, 32'd1000);       // silence
    send_sample(16'd300, 32'd1000);     // exactly on the gate
    send_sample(16'hFFFF, 32'd1000);    // press starts at full scale
    send_sample(16'hFFFF, 32'd1050);    // elapsed equals debounce: no click
    send_sample(16'd800, 32'd1051);     // click on the top key
    send_sample(16'd800, 32'd1100);
    send_sample(16'd800, 32'd1200);     // same key again, repeat rises
    send_poll();
    send_poll();                        // second poll finds the key cleared
    send_sample(16'd650, 32'd1300);
    send_sample(16'd650, 32'd1400);
    send_sample(16'd450, 32'hFFFF_FFF0);
    send_sample(16'd450, 32'h0000_0030); // timestamp wrapped during the press
    send_sample(16'd350, 32'd5000);
    send_sample(16'd350, 32'd5100);     // just above the gate: lowest key
    send_sample(16'd350, 32'd5200);
    send_sample(16'd350, 32'd5300);
    send_sample(16'd0, 32'd5400);       // release clears the repeat count
    send_sample(16'hFFFF, 32'd5500);
    send_sample(16'hFFFF, 32'd5600);
    send_poll();
    drain();

    // Random phases, each under its own register settings.
    for (phase = 1; phase <= RAND_PHASES; phase++) begin
      case (phase)
        1: begin
          new_btn = '0;
          foreach (new_thr[i]) new_thr[i] = '0;
          new_dbn = '0;
        end
        2: begin
          new_btn    = '1;
          new_thr[0] = '1;
          new_thr[1] = 16'd40000;
          new_thr[2] = 16'd20000;
          new_thr[3] = 16'd1;
          new_dbn    = '1;
        end
        3: begin
          new_btn    = 3'd1;
          new_thr[0] = '1;
          for (i = 1; i < NUM_THR; i++) new_thr[i] = CFG_DAT_W'($urandom);
          new_dbn    = '0;
        end
        4: begin
          new_btn = 3'd4;
          foreach (new_thr[i]) new_thr[i] = CFG_DAT_W'($urandom);
          new_dbn = CFG_DAT_W'($urandom_range(0, 15));
        end
        default: begin
          new_btn    = KEY_W'($urandom_range(0, 7));
          new_thr[0] = CFG_DAT_W'($urandom_range(400, RAW_TOP));
          for (i = 1; i < NUM_THR; i++) begin
            new_thr[i] = new_thr[i-1] - CFG_DAT_W'($urandom_range(1, new_thr[i-1] / 4 + 1));
          end
          new_dbn = ($urandom_range(0, 3) == 0) ? CFG_DAT_W'($urandom)
                                                 : CFG_DAT_W'($urandom_range(0, 30));
        end
      endcase
      write_reg(REG_BUTTON_COUNT, {(CFG_DAT_W - KEY_W)'($urandom), new_btn});
      write_reg(REG_THRESHOLD_1, new_thr[0]);
      write_reg(REG_THRESHOLD_2, new_thr[1]);
      write_reg(REG_THRESHOLD_3, new_thr[2]);
      write_reg(REG_THRESHOLD_4, new_thr[3]);
      write_reg(REG_DEBOUNCE, new_dbn);
      write_reg((phase % 2 != 0) ? REG_UNUSED_LO : REG_UNUSED_HI, CFG_DAT_W'($urandom));
      setting_cnt++;

      idle_on   = (phase % 3) != 0;
      stamp_now = $urandom;
      if (phase == HOLD_PHASE) hold_req = 1'b1;

      // Mostly well-formed presses, with polls, releases and stray samples mixed in.
      target   = queued_cnt + PHASE_REQS;
      prev_idx = 0;
      while (queued_cnt < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 3) stamp_now = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
        if (sel < 60) begin
          key_idx  = $urandom_range(0, 1) ? prev_idx : $urandom_range(0, keys_used() - 1);
          prev_idx = key_idx;
          queue_press(key_idx);
          if ($urandom_range(0, 2) == 0) queue_release();
        end else if (sel < 75) begin
          send_poll();
        end else if (sel < 90) begin
          send_sample(RAW_W'($urandom), $urandom_range(0, 1) ? $urandom : stamp_now);
        end else begin
          queue_release();
        end
      end
      drain();
    end

    $display("Sent %0d requests; checked %0d click events and %0d poll answers",
             req_cnt, click_cnt, poll_cnt);
    $display("under %0d settings, with wrapped timestamps, unordered thresholds, key-count %s",
             setting_cnt, "limits and a long receiver hold-off.");
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
